>>> design/isort_pkg.sv
// Shared types and constants for the insertion sorter.
package isort_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP,
    ST_PLACE,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // take in the new item
    logic issue;  // read the entry just below the insert position
    logic shift;  // move the read entry up one place
    logic place;  // write the new value at the insert position
    logic emit;   // read the next entry out to the result port
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic greater;     // read entry orders after the new value
    logic pos_zero;    // insert position at the bottom of the store
    logic pos_one;     // one entry left below the insert position
    logic emit_now;    // this insertion closes the set
    logic emit_final;  // current emit read is the last of the set
  } status_t;

endpackage

>>> design/isort_ram.sv
// Generic single-write, single-read RAM with registered read data.
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/isort_ctrl.sv
// Controller state machine of the insertion sorter.
module isort_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  isort_pkg::status_t    status,
  output isort_pkg::cmd_t       cmd
);

  isort_pkg::state_t state_r;
  isort_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isort_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      isort_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = isort_pkg::ST_ISSUE;
        end
      end
      isort_pkg::ST_ISSUE: begin
        if (status.pos_zero) begin
          cmd.place = 1'b1;
          state_nxt = status.emit_now ? isort_pkg::ST_EMIT : isort_pkg::ST_IDLE;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = isort_pkg::ST_CMP;
        end
      end
      isort_pkg::ST_CMP: begin
        if (status.greater) begin
          cmd.shift = 1'b1;
          if (status.pos_one) begin
            state_nxt = isort_pkg::ST_PLACE;
          end
        end else begin
          cmd.place = 1'b1;
          state_nxt = status.emit_now ? isort_pkg::ST_EMIT : isort_pkg::ST_IDLE;
        end
      end
      isort_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = status.emit_now ? isort_pkg::ST_EMIT : isort_pkg::ST_IDLE;
      end
      isort_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_final) begin
          state_nxt = isort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = isort_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/isort_dp.sv
// Datapath of the insertion sorter: store, pointers, compare, result register.
module isort_dp #(
  parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  isort_pkg::cmd_t                     cmd,
  output isort_pkg::status_t                  status,
  input  logic signed [isort_pkg::DATA_W-1:0] in_value,
  input  logic                                in_last_in,
  output logic                                out_valid,
  output logic signed [isort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                out_last_out
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [isort_pkg::DATA_W-1:0] v_r;
  logic                                last_r;
  logic [AW-1:0]                       pos_r;
  logic [CW-1:0]                       count_r;
  logic [AW-1:0]                       k_r;
  logic                                valid_r;
  logic                                olast_r;

  logic                        we;
  logic [AW-1:0]               waddr;
  logic [isort_pkg::DATA_W-1:0] wdata;
  logic [AW-1:0]               raddr;
  logic [isort_pkg::DATA_W-1:0] rdata;
  logic                        final_k;

  isort_ram #(
    .WIDTH (isort_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shift moves the entry below up; place drops the new value in the gap
  assign we    = cmd.shift | cmd.place;
  assign waddr = pos_r;
  assign wdata = cmd.shift ? rdata : v_r;

  always_comb begin
    if (cmd.issue) begin
      raddr = pos_r - AW'(1);
    end else if (cmd.shift) begin
      raddr = pos_r - AW'(2);
    end else begin
      raddr = k_r;
    end
  end

  assign final_k = (CW'(k_r) + CW'(1)) == count_r;

  assign status.greater    = $signed(rdata) > v_r;
  assign status.pos_zero   = pos_r == '0;
  assign status.pos_one    = pos_r == AW'(1);
  assign status.emit_now   = last_r || (count_r == CW'(DEPTH - 1));
  assign status.emit_final = final_k;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r    <= in_value;
      last_r <= in_last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      k_r     <= '0;
      valid_r <= 1'b0;
      olast_r <= 1'b0;
    end else begin
      valid_r <= cmd.emit;
      olast_r <= cmd.emit & final_k;
      if (cmd.load) begin
        pos_r <= count_r[AW-1:0];
      end else if (cmd.shift) begin
        pos_r <= pos_r - AW'(1);
      end
      if (cmd.place) begin
        count_r <= count_r + CW'(1);
        k_r     <= '0;
      end else if (cmd.emit) begin
        k_r <= k_r + AW'(1);
        if (final_k) begin
          count_r <= '0;
        end
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_last_out     = olast_r;
  assign out_sorted_value = $signed(rdata);

endmodule

>>> design/insertion_sorter.sv
// Insertion sorter: stable ascending sort of signed 32-bit values, flushed per set.
// After a transfer, busy stays high while the new value walks down past the held entries
//   greater than it, one shifted entry per cycle, and is written into the gap; the next transfer waits.
// A closing item (last_in set, or the DEPTH-th value) adds a read-out of all held entries; results
//   follow one per cycle, each in the cycle after its read; the receiver cannot stall them.
// Reset (rst_n low, synchronous) empties the set; store contents are left as they are.
module insertion_sorter #(
  parameter int DEPTH = isort_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel: transfer when start is high and busy is low
  input  logic                                start,
  output logic                                busy,
  input  logic signed [isort_pkg::DATA_W-1:0] in_value,
  input  logic                                in_last_in,
  // result channel: one-cycle strobe per result
  output logic                                out_valid,
  output logic signed [isort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                out_last_out
);

  isort_pkg::cmd_t    cmd;
  isort_pkg::status_t status;

  // Sequencing: load, then walk down the store comparing one entry per cycle,
  // moving larger entries up until the gap is found, then write the value and, if the set closes, read it out.
  isort_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Store, insert position, fill count, read-out pointer and result register.
  isort_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

endmodule

>>> design/insertion_sorter_chk.sv
// Port-level checker for the insertion sorter, bound to the top level.
module insertion_sorter_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last_out
);

  // a transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  // results only come out of a read-out phase
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without preceding work");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_out |-> out_valid)
    else $error("last flag outside a result");

  // read-out continues until the flagged result, then stops
  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_out) |-> busy)
    else $error("read-out ended before the last result");

  a_stop_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |=> !out_valid)
    else $error("result after the last of a set");

endmodule

bind insertion_sorter insertion_sorter_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_last_out (out_last_out)
);
